>>> rtl/far_pkg.sv
package far_pkg;

    // Operand and result widths
    localparam int IN_W  = 16;
    localparam int NUM_W = 2 * IN_W + 1;
    localparam int DEN_W = 2 * IN_W;
    localparam int SH_W  = $clog2(DEN_W);

    // Job queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Status codes
    localparam logic STAT_OK      = 1'b0;
    localparam logic STAT_ZERODEN = 1'b1;

    // Classified job handed from front to back
    typedef struct packed {
        logic             err;   // an input denominator was zero
        logic             zero;  // raw numerator is zero
        logic             neg;   // raw numerator is negative
        logic [DEN_W-1:0] mag;   // magnitude of raw numerator
        logic [DEN_W-1:0] den;   // raw denominator
    } far_job_t;

endpackage

>>> rtl/far_front.sv
module far_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [far_pkg::IN_W-1:0] num_a,
    input  logic [far_pkg::IN_W-1:0] den_a,
    input  logic [far_pkg::IN_W-1:0] num_b,
    input  logic [far_pkg::IN_W-1:0] den_b,
    output logic                     job_push,
    input  logic                     job_full,
    output far_pkg::far_job_t        job
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_SUM  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    localparam int IW = far_pkg::IN_W;
    localparam int NW = far_pkg::NUM_W;
    localparam int DW = far_pkg::DEN_W;

    logic [1:0] state_reg, state_next;

    logic signed [IW-1:0] na_reg;
    logic signed [IW-1:0] nb_reg;
    logic [IW-1:0]        da_reg;
    logic [IW-1:0]        db_reg;

    logic signed [NW-1:0] p_ad_reg;
    logic signed [NW-1:0] p_bd_reg;
    logic [DW-1:0]        p_dd_reg;
    far_pkg::far_job_t    job_reg;

    logic signed [NW-1:0] raw_num;
    logic [DW-1:0]        raw_den;
    logic signed [NW-1:0] raw_abs;
    logic                 den_eq;

    // Front FSM: one item in flight
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: if (push) state_next = F_MUL;
            F_MUL:  state_next = F_SUM;
            F_SUM:  state_next = F_PUSH;
            F_PUSH: if (!job_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign full     = (state_reg != F_IDLE);
    assign job_push = (state_reg == F_PUSH);
    assign job      = job_reg;

    // Capture operands
    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && push)
        begin
            na_reg <= num_a;
            nb_reg <= num_b;
            da_reg <= den_a;
            db_reg <= den_b;
        end
    end

    // Cross products, registered
    always_ff @(posedge clk)
    begin
        if (state_reg == F_MUL)
        begin
            p_ad_reg <= NW'(na_reg) * NW'(signed'({1'b0, db_reg}));
            p_bd_reg <= NW'(nb_reg) * NW'(signed'({1'b0, da_reg}));
            p_dd_reg <= DW'(da_reg) * DW'(db_reg);
        end
    end

    // Raw sum and classification
    always_comb
    begin
        den_eq = (da_reg == db_reg);
        if (den_eq)
        begin
            raw_num = NW'(na_reg) + NW'(nb_reg);
            raw_den = DW'(da_reg);
        end
        else
        begin
            raw_num = p_ad_reg + p_bd_reg;
            raw_den = p_dd_reg;
        end
        raw_abs = raw_num[NW-1] ? -raw_num : raw_num;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_SUM)
        begin
            job_reg.err  <= (da_reg == '0) || (db_reg == '0);
            job_reg.zero <= (raw_num == '0);
            job_reg.neg  <= raw_num[NW-1];
            job_reg.mag  <= raw_abs[DW-1:0];
            job_reg.den  <= raw_den;
        end
    end

endmodule

>>> rtl/far_queue.sv
module far_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    output logic              q_full,
    input  far_pkg::far_job_t wr_data,
    input  logic              rd_en,
    output logic              q_empty,
    output far_pkg::far_job_t rd_data
);

    localparam int QD = far_pkg::Q_DEPTH;
    localparam int PW = far_pkg::Q_PTR_W;
    localparam int CW = far_pkg::Q_CNT_W;

    far_pkg::far_job_t slot_reg [QD];

    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_wr;
    logic          do_rd;

    assign q_full  = (cnt_reg == CW'(QD));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(QD))
        else $error("job queue count above depth");

    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("job queue count missed a write");
`endif

endmodule

>>> rtl/far_back.sv
module far_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      job_empty,
    output logic                      job_pop,
    input  far_pkg::far_job_t         job,
    output logic                      res_valid,
    input  logic                      res_take,
    output logic [far_pkg::NUM_W-1:0] res_num,
    output logic [far_pkg::DEN_W-1:0] res_den,
    output logic                      res_status
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_GCD  = 2'd1;
    localparam logic [1:0] B_DIV  = 2'd2;
    localparam logic [1:0] B_DONE = 2'd3;

    localparam int NW = far_pkg::NUM_W;
    localparam int DW = far_pkg::DEN_W;
    localparam int SW = far_pkg::SH_W;

    logic [1:0]    state_reg;
    logic [DW-1:0] ga_reg, gb_reg;
    logic [SW-1:0] k_reg;
    logic [DW-1:0] g_reg;
    logic [SW-1:0] cnt_reg;
    logic          neg_reg;
    logic [DW-1:0] qn_reg, qd_reg;     // dividends shift out, quotients shift in
    logic [DW-1:0] rn_reg, rd_reg;     // partial remainders
    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic          stat_reg;

    logic [DW-1:0] ga_next, gb_next;
    logic [SW-1:0] k_next;
    logic          gcd_done;
    logic [DW:0]   rn_sh, rd_sh;
    logic          bn, bd;
    logic [DW:0]   g_ext;
    logic [DW-1:0] qn_fin, qd_fin;

    assign job_pop    = (state_reg == B_IDLE) && !job_empty;
    assign res_valid  = (state_reg == B_DONE);
    assign res_num    = num_reg;
    assign res_den    = den_reg;
    assign res_status = stat_reg;

    // Binary gcd step: halve even values, subtract odd ones
    always_comb
    begin
        ga_next  = ga_reg;
        gb_next  = gb_reg;
        k_next   = k_reg;
        gcd_done = (ga_reg == gb_reg);
        if (!ga_reg[0] && !gb_reg[0])
        begin
            ga_next = ga_reg >> 1;
            gb_next = gb_reg >> 1;
            k_next  = k_reg + 1'b1;
        end
        else if (!ga_reg[0])
        begin
            ga_next = ga_reg >> 1;
        end
        else if (!gb_reg[0])
        begin
            gb_next = gb_reg >> 1;
        end
        else if (ga_reg > gb_reg)
        begin
            ga_next = (ga_reg - gb_reg) >> 1;
        end
        else
        begin
            gb_next = (gb_reg - ga_reg) >> 1;
        end
    end

    // Two restoring divide lanes sharing the divisor
    always_comb
    begin
        g_ext = {1'b0, g_reg};
        rn_sh = {rn_reg, qn_reg[DW-1]};
        rd_sh = {rd_reg, qd_reg[DW-1]};
        bn    = (rn_sh >= g_ext);
        bd    = (rd_sh >= g_ext);
        qn_fin = {qn_reg[DW-2:0], bn};
        qd_fin = {qd_reg[DW-2:0], bd};
    end

    // Back FSM
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            case (state_reg)
                B_IDLE:
                begin
                    if (!job_empty)
                    begin
                        state_reg <= (job.err || job.zero) ? B_DONE : B_GCD;
                    end
                end
                B_GCD:   if (gcd_done) state_reg <= B_DIV;
                B_DIV:   if (cnt_reg == SW'(DW - 1)) state_reg <= B_DONE;
                B_DONE:  if (res_take) state_reg <= B_IDLE;
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                ga_reg   <= job.mag;
                gb_reg   <= job.den;
                k_reg    <= '0;
                neg_reg  <= job.neg;
                qn_reg   <= job.mag;
                qd_reg   <= job.den;
                stat_reg <= job.err ? far_pkg::STAT_ZERODEN : far_pkg::STAT_OK;
                num_reg  <= '0;
                den_reg  <= job.err ? '0 : DW'(1);
            end
            B_GCD:
            begin
                if (gcd_done)
                begin
                    g_reg   <= DW'(ga_reg << k_reg);
                    cnt_reg <= '0;
                    rn_reg  <= '0;
                    rd_reg  <= '0;
                end
                else
                begin
                    ga_reg <= ga_next;
                    gb_reg <= gb_next;
                    k_reg  <= k_next;
                end
            end
            B_DIV:
            begin
                rn_reg  <= bn ? DW'(rn_sh - g_ext) : rn_sh[DW-1:0];
                rd_reg  <= bd ? DW'(rd_sh - g_ext) : rd_sh[DW-1:0];
                qn_reg  <= qn_fin;
                qd_reg  <= qd_fin;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == SW'(DW - 1))
                begin
                    num_reg <= neg_reg ? -{1'b0, qn_fin} : {1'b0, qn_fin};
                    den_reg <= qd_fin;
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_GCD) |-> (ga_reg != '0 && gb_reg != '0))
        else $error("gcd operand reached zero");

    a_den_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_status == far_pkg::STAT_OK) |-> (res_den != '0))
        else $error("zero denominator on a good result");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_status == far_pkg::STAT_ZERODEN) |-> (res_num == '0 && res_den == '0))
        else $error("error result not 0/0");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_take) |=> (res_valid && $stable(res_num) && $stable(res_den)))
        else $error("result changed before it was taken");
`endif

endmodule

>>> rtl/fraction_add_reduce_unit.sv
// The front multiplies, sums and hands the job off, holding it while the queue is full;
// the job waits in the 2-entry job queue; the back then runs binary gcd steps, finishes
// the gcd and runs the 32-step divider; error and zero-sum items skip gcd and divider.
// The back takes a new job only after its result is popped, so its gcd loop and the
// 32-step divider set the rate; the 2-entry queue lets the front take items meanwhile.
// Reset: rst_n is asynchronous, active low; it empties the queue and idles both FSMs.
module fraction_add_reduce_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [far_pkg::IN_W-1:0]  num_a,
    input  logic [far_pkg::IN_W-1:0]  den_a,
    input  logic [far_pkg::IN_W-1:0]  num_b,
    input  logic [far_pkg::IN_W-1:0]  den_b,
    output logic                      empty,
    input  logic                      pop,
    output logic [far_pkg::NUM_W-1:0] sum_num,
    output logic [far_pkg::DEN_W-1:0] sum_den,
    output logic                      status
);

    logic              job_push;
    logic              job_full;
    logic              job_pop;
    logic              job_empty;
    far_pkg::far_job_t job_in;
    far_pkg::far_job_t job_out;
    logic              res_valid;

    // Accept and classify
    far_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .num_a    (num_a),
        .den_a    (den_a),
        .num_b    (num_b),
        .den_b    (den_b),
        .job_push (job_push),
        .job_full (job_full),
        .job      (job_in)
    );

    // Decoupling queue
    far_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .q_full  (job_full),
        .wr_data (job_in),
        .rd_en   (job_pop),
        .q_empty (job_empty),
        .rd_data (job_out)
    );

    // Reduce and hold result
    far_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_empty  (job_empty),
        .job_pop    (job_pop),
        .job        (job_out),
        .res_valid  (res_valid),
        .res_take   (pop),
        .res_num    (sum_num),
        .res_den    (sum_den),
        .res_status (status)
    );

    assign empty = !res_valid;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int IN_W  = far_pkg::IN_W;
    localparam int NUM_W = far_pkg::NUM_W;
    localparam int DEN_W = far_pkg::DEN_W;

    // Operand pair offered on one item
    typedef struct packed {
        logic [IN_W-1:0] na;
        logic [IN_W-1:0] da;
        logic [IN_W-1:0] nb;
        logic [IN_W-1:0] db;
    } fraction_pair_t;

    // Reduced sum returned for one item
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             stat;
    } reduced_sum_t;

    // Directed row: pair plus an optional hand-written answer
    typedef struct packed {
        fraction_pair_t pair;
        logic           typed;
        reduced_sum_t   sum;
    } stim_row_t;

    localparam int RANDOM_ITEMS = 400;
    localparam int HOLD_CYCLES  = 1500;
    localparam int DRAIN_CYCLES = 200;

    logic             clk;
    logic             rst_n;
    logic             push;
    logic             full;
    logic [IN_W-1:0]  num_a;
    logic [IN_W-1:0]  den_a;
    logic [IN_W-1:0]  num_b;
    logic [IN_W-1:0]  den_b;
    logic             empty;
    logic             pop;
    logic [NUM_W-1:0] sum_num;
    logic [DEN_W-1:0] sum_den;
    logic             status;

    reduced_sum_t pending_sums[$];
    stim_row_t    stim_rows[$];
    int           mismatch_cnt = 0;
    int           accepted_cnt = 0;

    fraction_add_reduce_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .num_a   (num_a),
        .den_a   (den_a),
        .num_b   (num_b),
        .den_b   (den_b),
        .empty   (empty),
        .pop     (pop),
        .sum_num (sum_num),
        .sum_den (sum_den),
        .status  (status)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("fraction_add_reduce_unit regression: fail");
        $finish;
    end

    // Sum of two fractions in lowest terms
    function automatic reduced_sum_t reduce_fraction_sum(input fraction_pair_t p);
        reduced_sum_t r;
        longint na, nb, da, db, n, d, mag, x, y, t, q;
        na = $signed(p.na);
        nb = $signed(p.nb);
        da = p.da;
        db = p.db;
        r.num  = '0;
        r.den  = '0;
        r.stat = far_pkg::STAT_OK;
        if (da == 0 || db == 0)
        begin
            r.stat = far_pkg::STAT_ZERODEN;
            return r;
        end
        if (da == db)
        begin
            n = na + nb;
            d = da;
        end
        else
        begin
            n = na * db + nb * da;
            d = da * db;
        end
        if (n == 0)
        begin
            r.den = 1;
            return r;
        end
        mag = (n < 0) ? -n : n;
        // Euclid on magnitude and denominator
        x = mag;
        y = d;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        q = mag / x;
        d = d / x;
        if (n < 0)
            q = -q;
        r.num = q[NUM_W-1:0];
        r.den = d[DEN_W-1:0];
        return r;
    endfunction

    task automatic add_row(input int na, input int da, input int nb, input int db,
                           input bit typed, input longint exp_num, input longint exp_den,
                           input logic exp_stat);
        stim_row_t r;
        r.pair.na  = na[IN_W-1:0];
        r.pair.da  = da[IN_W-1:0];
        r.pair.nb  = nb[IN_W-1:0];
        r.pair.db  = db[IN_W-1:0];
        r.typed    = typed;
        r.sum.num  = exp_num[NUM_W-1:0];
        r.sum.den  = exp_den[DEN_W-1:0];
        r.sum.stat = exp_stat;
        stim_rows.push_back(r);
    endtask

    // Random pair, weighted toward the interesting corners
    function automatic fraction_pair_t random_pair();
        fraction_pair_t p;
        int kind, k;
        int ext_num[5];
        int ext_den[4];
        ext_num = '{-32768, -1, 0, 1, 32767};
        ext_den = '{1, 2, 65534, 65535};
        kind = $urandom_range(0, 99);
        p.na = IN_W'($urandom);
        p.nb = IN_W'($urandom);
        p.da = IN_W'($urandom);
        p.db = IN_W'($urandom);
        if (kind < 5)
        begin
            // zero denominator on one or both sides
            k = $urandom_range(0, 2);
            if (k != 1)
                p.da = '0;
            if (k != 0)
                p.db = '0;
        end
        else if (kind < 25)
        begin
            // equal denominators
            p.da = ($urandom_range(0, 1) != 0) ? IN_W'($urandom_range(1, 64))
                                               : IN_W'($urandom_range(1, 65535));
            p.db = p.da;
        end
        else if (kind < 40)
        begin
            // sums that cancel to zero
            p.da = IN_W'($urandom_range(1, 32767));
            p.na = IN_W'($urandom_range(0, 32766) - 16383);
            if ($urandom_range(0, 1) != 0)
            begin
                p.db = p.da;
                p.nb = -p.na;
            end
            else
            begin
                p.db = p.da << 1;
                p.nb = -(p.na << 1);
            end
        end
        else if (kind < 55)
        begin
            p.na = IN_W'(ext_num[$urandom_range(0, 4)]);
            p.nb = IN_W'(ext_num[$urandom_range(0, 4)]);
            p.da = IN_W'(ext_den[$urandom_range(0, 3)]);
            p.db = IN_W'(ext_den[$urandom_range(0, 3)]);
        end
        else if (kind < 80)
        begin
            p.da = IN_W'($urandom_range(1, 64));
            p.db = IN_W'($urandom_range(1, 64));
        end
        return p;
    endfunction

    // Offer one item; returns once it has been taken
    task automatic offer_item(input stim_row_t r);
        push  <= 1'b1;
        num_a <= r.pair.na;
        den_a <= r.pair.da;
        num_b <= r.pair.nb;
        den_b <= r.pair.db;
        @(posedge clk);
        while (full)
            @(posedge clk);
        accepted_cnt++;
        if (r.typed)
            pending_sums.push_back(r.sum);
        else
            pending_sums.push_back(reduce_fraction_sum(r.pair));
    endtask

    // Sender: reset, directed rows, then random items in bursts
    initial
    begin
        stim_row_t r;
        int burst_left;
        int gap;
        rst_n <= 1'b0;
        push  <= 1'b0;
        num_a <= '0;
        den_a <= '0;
        num_b <= '0;
        den_b <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero denominators
        add_row(1, 0, 1, 1, 1'b1, 0, 0, far_pkg::STAT_ZERODEN);
        add_row(1, 1, 1, 0, 1'b1, 0, 0, far_pkg::STAT_ZERODEN);
        add_row(0, 0, 0, 0, 1'b1, 0, 0, far_pkg::STAT_ZERODEN);
        add_row(-32768, 0, 32767, 65535, 1'b1, 0, 0, far_pkg::STAT_ZERODEN);
        // zero sums
        add_row(0, 1, 0, 1, 1'b1, 0, 1, far_pkg::STAT_OK);
        add_row(1, 2, -1, 2, 1'b1, 0, 1, far_pkg::STAT_OK);
        add_row(-1, 1, 1, 1, 1'b1, 0, 1, far_pkg::STAT_OK);
        // equal denominators, extremes and a reducible case
        add_row(-32768, 1, -32768, 1, 1'b1, -65536, 1, far_pkg::STAT_OK);
        add_row(32767, 1, 32767, 1, 1'b1, 65534, 1, far_pkg::STAT_OK);
        add_row(1, 65535, 1, 65535, 1'b1, 2, 65535, far_pkg::STAT_OK);
        add_row(3, 6, 3, 6, 1'b1, 1, 1, far_pkg::STAT_OK);
        // cross-multiplied
        add_row(1, 2, 1, 3, 1'b1, 5, 6, far_pkg::STAT_OK);
        add_row(1, 2, 1, 4, 1'b1, 3, 4, far_pkg::STAT_OK);
        add_row(5, 1, 0, 7, 1'b1, 5, 1, far_pkg::STAT_OK);
        add_row(32767, 65535, 32767, 65534, 1'b0, 0, 0, far_pkg::STAT_OK);
        add_row(-32768, 65535, -32768, 65534, 1'b0, 0, 0, far_pkg::STAT_OK);
        add_row(-32768, 65535, 32767, 65534, 1'b0, 0, 0, far_pkg::STAT_OK);
        add_row(32767, 1, -32768, 65535, 1'b0, 0, 0, far_pkg::STAT_OK);
        add_row(-1, 65535, -1, 1, 1'b0, 0, 0, far_pkg::STAT_OK);
        add_row(12345, 100, -6789, 250, 1'b0, 0, 0, far_pkg::STAT_OK);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            r.pair  = random_pair();
            r.typed = 1'b0;
            r.sum   = '0;
            stim_rows.push_back(r);
        end

        burst_left = 0;
        foreach (stim_rows[i])
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                if (gap > 0)
                begin
                    push <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                // now and then a long unbroken stretch
                burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
            end
            burst_left--;
            offer_item(stim_rows[i]);
        end
        push <= 1'b0;

        // drain
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("fraction_add_reduce_unit regression: pass");
        else
            $display("fraction_add_reduce_unit regression: fail");
        $finish;
    end

    // Receiver: checks each popped result, stalls on its own pattern
    initial
    begin
        reduced_sum_t want;
        int  hold_cnt;
        bit  hold_done;
        int  phase_cnt;
        int  mode;
        logic next_pop;
        hold_cnt  = 0;
        hold_done = 1'b0;
        phase_cnt = 0;
        mode      = 0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (pending_sums.size() == 0)
                begin
                    $error("unexpected result: sum_num %0d sum_den %0d status %0d",
                           $signed(sum_num), sum_den, status);
                    mismatch_cnt++;
                end
                else
                begin
                    want = pending_sums.pop_front();
                    if (sum_num !== want.num)
                    begin
                        $error("sum_num: expected %0d, actual %0d",
                               $signed(want.num), $signed(sum_num));
                        mismatch_cnt++;
                    end
                    if (sum_den !== want.den)
                    begin
                        $error("sum_den: expected %0d, actual %0d", want.den, sum_den);
                        mismatch_cnt++;
                    end
                    if (status !== want.stat)
                    begin
                        $error("status: expected %0d, actual %0d", want.stat, status);
                        mismatch_cnt++;
                    end
                end
            end

            // pick the next pop
            phase_cnt++;
            if (phase_cnt % 50 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0:       next_pop = 1'b1;
                1:       next_pop = ($urandom_range(0, 1) != 0);
                2:       next_pop = (phase_cnt % 4 == 0);
                default: next_pop = ($urandom_range(0, 7) != 0);
            endcase
            // one long hold-off so the block backs up into full
            if (!hold_done && accepted_cnt >= 60)
            begin
                hold_done = 1'b1;
                hold_cnt  = HOLD_CYCLES;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                next_pop = 1'b0;
            end
            pop <= next_pop;
        end
    end

endmodule

>>> filelist.f
rtl/far_pkg.sv
rtl/far_front.sv
rtl/far_queue.sv
rtl/far_back.sv
rtl/fraction_add_reduce_unit.sv
dv/tb_top.sv
